FILE: rtl/fss_pkg.sv
// shared types and constants for the first substring match search
package fss_pkg;

    localparam int MaxPatternLen = 16;
    localparam int MaxSourceLen  = 65536;
    localparam int LenWidth      = 5;
    localparam int WinIdxWidth   = 4;
    localparam int CountWidth    = 17;
    localparam int OffsetWidth   = 16;
    localparam int CfgDataWidth  = 64;
    localparam int CfgIdxWidth   = 2;
    localparam int PatternWidth  = 8 * MaxPatternLen;

    localparam logic [CfgIdxWidth-1:0] RegPatternLength = 2'd0;
    localparam logic [CfgIdxWidth-1:0] RegPatternLow    = 2'd1;
    localparam logic [CfgIdxWidth-1:0] RegPatternHigh   = 2'd2;

    localparam logic [1:0] StFound    = 2'd0;
    localparam logic [1:0] StNotFound = 2'd1;
    localparam logic [1:0] StShort    = 2'd2;
    localparam logic [1:0] StTooLong  = 2'd3;

    typedef struct packed {
        logic [7:0] source_byte;
        logic       last_byte;
    } fss_in_t;

    typedef struct packed {
        logic [1:0]             status;
        logic [OffsetWidth-1:0] match_offset;
    } fss_out_t;

endpackage

FILE: rtl/first_substring_match_search.sv
// first substring match search, top level with input register
// a source byte is registered in the input register, then its result in the output register
// throughput: one source byte per cycle, held back only by result backpressure
// a result waits in the output register while the next byte sits in the input register
// reset clears window, byte count, found flag, pattern length to one and pattern bytes to zero
module first_substring_match_search (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              src_valid,
    output logic                              src_ready,
    input  fss_pkg::fss_in_t                  src,
    output logic                              res_valid,
    input  logic                              res_ready,
    output fss_pkg::fss_out_t                 res,
    input  logic                              cfg_we,
    input  logic [fss_pkg::CfgIdxWidth-1:0]   cfg_index,
    input  logic [fss_pkg::CfgDataWidth-1:0]  cfg_data
);

    logic                             in_valid_reg;
    logic                             in_valid_next;
    fss_pkg::fss_in_t                 in_reg;
    logic                             advance;
    logic [fss_pkg::LenWidth-1:0]     eff_len;
    logic [fss_pkg::PatternWidth-1:0] pattern;

    // the held byte moves on once the result register is free or being emptied
    assign advance       = in_valid_reg && (!res_valid || res_ready);
    assign src_ready     = !in_valid_reg || advance;
    assign in_valid_next = src_valid ? 1'b1 : (advance ? 1'b0 : in_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (src_ready)
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (src_valid && src_ready)
            in_reg <= src;
    end

    fss_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .eff_len   (eff_len),
        .pattern   (pattern)
    );

    fss_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .item      (in_reg),
        .eff_len   (eff_len),
        .pattern   (pattern),
        .res_ready (res_ready),
        .res_valid (res_valid),
        .res       (res)
    );

endmodule

FILE: rtl/fss_cfg.sv
// configuration registers: pattern length and pattern bytes
module fss_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [fss_pkg::CfgIdxWidth-1:0]     cfg_index,
    input  logic [fss_pkg::CfgDataWidth-1:0]    cfg_data,
    output logic [fss_pkg::LenWidth-1:0]        eff_len,
    output logic [fss_pkg::PatternWidth-1:0]    pattern
);

    logic [fss_pkg::LenWidth-1:0]     len_reg;
    logic [fss_pkg::CfgDataWidth-1:0] pat_low_reg;
    logic [fss_pkg::CfgDataWidth-1:0] pat_high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg      <= fss_pkg::LenWidth'(1);
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fss_pkg::RegPatternLength: len_reg <= cfg_data[fss_pkg::LenWidth-1:0];
                fss_pkg::RegPatternLow:    pat_low_reg <= cfg_data;
                fss_pkg::RegPatternHigh:   pat_high_reg <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // zero acts as one, anything above the maximum acts as the maximum
    always_comb
    begin
        if (len_reg == '0)
            eff_len = fss_pkg::LenWidth'(1);
        else if (len_reg > fss_pkg::LenWidth'(fss_pkg::MaxPatternLen))
            eff_len = fss_pkg::LenWidth'(fss_pkg::MaxPatternLen);
        else
            eff_len = len_reg;
    end

    assign pattern = {pat_high_reg, pat_low_reg};

endmodule

FILE: rtl/fss_core.sv
// sliding window, byte counter, pattern compare and result register
module fss_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             advance,
    input  fss_pkg::fss_in_t                 item,
    input  logic [fss_pkg::LenWidth-1:0]     eff_len,
    input  logic [fss_pkg::PatternWidth-1:0] pattern,
    input  logic                             res_ready,
    output logic                             res_valid,
    output fss_pkg::fss_out_t                res
);

    logic [7:0]                      win_reg  [fss_pkg::MaxPatternLen];
    logic [7:0]                      win_next [fss_pkg::MaxPatternLen];
    logic [fss_pkg::CountWidth-1:0]  count_reg;
    logic [fss_pkg::CountWidth-1:0]  count_next;
    logic                            found_reg;
    logic                            found_next;
    logic                            res_valid_reg;
    logic                            res_valid_next;
    fss_pkg::fss_out_t               res_reg;
    fss_pkg::fss_out_t               res_next;

    logic [7:0]                      shifted [fss_pkg::MaxPatternLen];
    logic [fss_pkg::CountWidth-1:0]  count_inc;
    logic [fss_pkg::CountWidth-1:0]  len_ext;
    logic [fss_pkg::WinIdxWidth-1:0] widx;
    logic                            in_range;
    logic                            window_hit;
    logic                            hit;

    assign in_range  = count_reg < fss_pkg::CountWidth'(fss_pkg::MaxSourceLen);
    assign count_inc = count_reg + fss_pkg::CountWidth'(1);
    assign len_ext   = fss_pkg::CountWidth'(eff_len);

    // window as it stands after taking this byte, entry 0 newest
    always_comb
    begin
        shifted[0] = item.source_byte;
        for (int k = 1; k < fss_pkg::MaxPatternLen; k++)
            shifted[k] = win_reg[k-1];
    end

    // pattern byte i must sit at window entry len-1-i
    always_comb
    begin
        window_hit = 1'b1;
        widx       = '0;
        for (int i = 0; i < fss_pkg::MaxPatternLen; i++)
        begin
            widx = fss_pkg::WinIdxWidth'(eff_len - fss_pkg::LenWidth'(1)
                                        - fss_pkg::LenWidth'(i));
            if (fss_pkg::LenWidth'(i) < eff_len && shifted[widx] != pattern[i*8 +: 8])
                window_hit = 1'b0;
        end
    end

    assign hit = in_range && !found_reg && count_inc >= len_ext && window_hit;

    always_comb
    begin
        win_next       = win_reg;
        count_next     = count_reg;
        found_next     = found_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        if (res_ready)
            res_valid_next = 1'b0;
        if (advance)
        begin
            res_valid_next = 1'b0;
            if (in_range)
            begin
                win_next   = shifted;
                count_next = count_inc;
            end
            else
                count_next = fss_pkg::CountWidth'(fss_pkg::MaxSourceLen + 1);
            if (hit)
            begin
                found_next            = 1'b1;
                res_valid_next        = 1'b1;
                res_next.status       = fss_pkg::StFound;
                res_next.match_offset = fss_pkg::OffsetWidth'(count_inc - len_ext);
            end
            if (item.last_byte)
            begin
                if (!found_reg && !hit)
                begin
                    res_valid_next        = 1'b1;
                    res_next.match_offset = '0;
                    if (!in_range)
                        res_next.status = fss_pkg::StTooLong;
                    else if (count_inc < len_ext)
                        res_next.status = fss_pkg::StShort;
                    else
                        res_next.status = fss_pkg::StNotFound;
                end
                for (int k = 0; k < fss_pkg::MaxPatternLen; k++)
                    win_next[k] = '0;
                count_next = '0;
                found_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < fss_pkg::MaxPatternLen; k++)
                win_reg[k] <= '0;
            count_reg     <= '0;
            found_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            win_reg       <= win_next;
            count_reg     <= count_next;
            found_reg     <= found_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

FILE: tb/tb.sv
// testbench for first_substring_match_search: directed and random sources
`timescale 1ns / 100ps

module tb;

    localparam logic [fss_pkg::CfgIdxWidth-1:0] RegUnused = 2'd3;
    localparam int IdlePercent = 35;
    localparam int RandomBytes = 750;
    localparam int TimeoutCycles = 2_000_000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic src_valid = 1'b0;
    logic src_ready;
    fss_pkg::fss_in_t src = '0;
    logic res_valid;
    logic res_ready = 1'b0;
    fss_pkg::fss_out_t res;
    logic cfg_we = 1'b0;
    logic [fss_pkg::CfgIdxWidth-1:0] cfg_index = '0;
    logic [fss_pkg::CfgDataWidth-1:0] cfg_data = '0;

    // no random idling on either side while set
    bit steady = 1'b0;
    int fail_count = 0;

    // predictor copy of registers and search state
    logic [fss_pkg::LenWidth-1:0] pat_len_reg = 5'd1;
    logic [fss_pkg::PatternWidth-1:0] pat_bits = '0;
    logic [7:0] search_window [fss_pkg::MaxPatternLen] = '{default: 8'h00};
    int unsigned search_count = 0;
    bit match_seen = 1'b0;

    fss_pkg::fss_out_t awaited_outcomes [$];

    first_substring_match_search u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src       (src),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        res_ready <= steady || ($urandom_range(99) >= IdlePercent);
    end

    function automatic int unsigned pattern_span();
        if (pat_len_reg == 0)
            return 1;
        if (pat_len_reg > fss_pkg::MaxPatternLen)
            return fss_pkg::MaxPatternLen;
        return 32'(pat_len_reg);
    endfunction

    // one source byte through the search, pushing the outcome it causes
    function automatic void search_step(input logic [7:0] b, input logic last);
        int unsigned span;
        bit hit;
        fss_pkg::fss_out_t outcome;
        span = pattern_span();
        if (search_count < fss_pkg::MaxSourceLen)
        begin
            for (int i = fss_pkg::MaxPatternLen - 1; i > 0; i--)
                search_window[i] = search_window[i - 1];
            search_window[0] = b;
            search_count++;
            if (!match_seen && search_count >= span)
            begin
                hit = 1'b1;
                for (int i = 0; i < span; i++)
                    if (search_window[span - 1 - i] != pat_bits[8 * i +: 8])
                        hit = 1'b0;
                if (hit)
                begin
                    match_seen = 1'b1;
                    outcome.status = fss_pkg::StFound;
                    outcome.match_offset = fss_pkg::OffsetWidth'(search_count - span);
                    awaited_outcomes.push_back(outcome);
                end
            end
        end
        else
            search_count = fss_pkg::MaxSourceLen + 1;
        if (last)
        begin
            if (!match_seen)
            begin
                if (search_count > fss_pkg::MaxSourceLen)
                    outcome.status = fss_pkg::StTooLong;
                else if (search_count < span)
                    outcome.status = fss_pkg::StShort;
                else
                    outcome.status = fss_pkg::StNotFound;
                outcome.match_offset = '0;
                awaited_outcomes.push_back(outcome);
            end
            search_window = '{default: 8'h00};
            search_count = 0;
            match_seen = 1'b0;
        end
    endfunction

    // result checker
    always @(posedge clk)
    begin : check_outcomes
        fss_pkg::fss_out_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (awaited_outcomes.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: status %0d offset %0d",
                             res.status, res.match_offset);
            end
            else
            begin
                want = awaited_outcomes.pop_front();
                if (res.status !== want.status || res.match_offset !== want.match_offset)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"mismatch: expected status %0d offset %0d, ",
                                  "got status %0d offset %0d"},
                                 want.status, want.match_offset,
                                 res.status, res.match_offset);
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        cfg_we <= 1'b0;
        while (!steady && $urandom_range(99) < IdlePercent)
        begin
            src_valid <= 1'b0;
            @(posedge clk);
        end
        src_valid <= 1'b1;
        src <= '{source_byte: b, last_byte: last};
        @(posedge clk);
        while (!src_ready)
            @(posedge clk);
        search_step(b, last);
    endtask

    // let every outstanding result arrive, then cover the pipeline latency
    task automatic drain();
        src_valid <= 1'b0;
        cfg_we <= 1'b0;
        @(posedge clk);
        while (awaited_outcomes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // write enable stays high until the next transfer or drain lowers it
    task automatic write_reg(input logic [fss_pkg::CfgIdxWidth-1:0] idx,
                             input logic [63:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            fss_pkg::RegPatternLength: pat_len_reg = data[fss_pkg::LenWidth-1:0];
            fss_pkg::RegPatternLow: pat_bits[63:0] = data;
            fss_pkg::RegPatternHigh: pat_bits[127:64] = data;
            default: ;
        endcase
    endtask

    task automatic set_pattern(input logic [63:0] len_word, input logic [63:0] lo,
                               input logic [63:0] hi);
        write_reg(fss_pkg::RegPatternLength, len_word);
        write_reg(fss_pkg::RegPatternLow, lo);
        write_reg(fss_pkg::RegPatternHigh, hi);
    endtask

    // reset pattern is a single zero byte; bytes after the match stay silent
    task automatic test_default_pattern();
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        drain();
    endtask

    // full-length pattern with extreme bytes, completed by the last byte
    task automatic test_full_pattern();
        logic [63:0] hi;
        hi = {$urandom, $urandom};
        hi[63:56] = 8'hFF;
        hi[7:0] = 8'h00;
        set_pattern(64'd16, 64'h7F80_01FE_00FF_AA55, hi);
        for (int i = 0; i < fss_pkg::MaxPatternLen; i++)
            send_byte(pat_bits[8 * i +: 8], i == fss_pkg::MaxPatternLen - 1);
        drain();
    endtask

    // zero window must not match before enough bytes have arrived
    task automatic test_short_source();
        set_pattern(64'd4, 64'd0, 64'd0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h9C, 1'b1);
        drain();
    endtask

    // length field masked to five bits, zero acts as one, above sixteen as sixteen
    task automatic test_length_range();
        logic [63:0] len_word;
        set_pattern(64'hFFFF_FFFF_FFFF_FFE0, 64'hA5, '1);
        send_byte(8'h5A, 1'b1);
        send_byte(8'hA5, 1'b1);
        drain();
        len_word = {$urandom, $urandom};
        len_word[4:0] = 5'd31;
        write_reg(fss_pkg::RegPatternLength, len_word);
        send_byte(8'hA5, 1'b1);
        drain();
        len_word[4:0] = 5'd17;
        write_reg(fss_pkg::RegPatternLength, len_word);
        send_byte(8'hA5, 1'b1);
        drain();
    endtask

    task automatic test_unused_index();
        set_pattern(64'd1, 64'hA5, 64'd0);
        write_reg(RegUnused, '1);
        send_byte(8'hA5, 1'b1);
        drain();
    endtask

    // pattern swapped while a source is half way through
    task automatic test_midsource_write();
        set_pattern(64'd3, 64'h43_4241, 64'd0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b0);
        drain();
        set_pattern(64'd2, 64'h4342, 64'd0);
        send_byte(8'h43, 1'b1);
        drain();
    endtask

    task automatic test_random_sources();
        int sent;
        int unsigned span;
        int src_len;
        int pos;
        int pick;
        int noise_len;
        logic [63:0] len_word;
        logic [127:0] bytes_pick;
        logic [7:0] text [$];
        sent = 0;
        while (sent < RandomBytes)
        begin
            steady = (sent >= 300 && sent < 450);
            if (sent == 0 || $urandom_range(3) == 0)
            begin
                drain();
                len_word = {$urandom, $urandom};
                pick = $urandom_range(9);
                if (pick < 6)
                    len_word[4:0] = 5'($urandom_range(1, 5));
                else if (pick == 6)
                    len_word[4:0] = 5'($urandom_range(6, 16));
                else if (pick == 7)
                    len_word[4:0] = 5'd16;
                else if (pick == 8)
                    len_word[4:0] = 5'd0;
                else
                    len_word[4:0] = 5'($urandom_range(17, 31));
                bytes_pick = {$urandom, $urandom, $urandom, $urandom};
                // a two-letter alphabet gives overlapping partial matches
                if ($urandom_range(1) == 0)
                    for (int i = 0; i < fss_pkg::MaxPatternLen; i++)
                        bytes_pick[8 * i +: 8] = 8'h41 + 8'($urandom_range(1));
                set_pattern(len_word, bytes_pick[63:0], bytes_pick[127:64]);
            end
            span = pattern_span();
            if ($urandom_range(9) < 8)
            begin
                src_len = ($urandom_range(7) == 0) ? $urandom_range(1, 64)
                                                   : $urandom_range(1, 20);
                text.delete();
                for (int k = 0; k < src_len; k++)
                begin
                    pick = $urandom_range(span - 1);
                    text.push_back($urandom_range(1) ? pat_bits[8 * pick +: 8]
                                                     : 8'($urandom));
                end
                if ($urandom_range(2) != 0 && src_len >= span)
                begin
                    pos = $urandom_range(src_len - span);
                    for (int k = 0; k < span; k++)
                        text[pos + k] = pat_bits[8 * k +: 8];
                end
                for (int k = 0; k < src_len; k++)
                    send_byte(text[k], k == src_len - 1);
                sent += src_len;
            end
            else
            begin
                // noise: random bytes, end marker at random or not at all
                noise_len = $urandom_range(1, 12);
                for (int k = 0; k < noise_len; k++)
                    send_byte(8'($urandom), $urandom_range(7) == 0);
                sent += noise_len;
            end
        end
        steady = 1'b0;
        drain();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_pattern();
        test_full_pattern();
        test_short_source();
        test_length_range();
        test_unused_index();
        test_midsource_write();
        test_random_sources();
        drain();
        if (fail_count == 0 && awaited_outcomes.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #(12 * TimeoutCycles);
        $display("status: fail");
        $finish;
    end

endmodule
